// File: hw/rtl/wdpf_pkg.sv
package wdpf_pkg;

  // Pipeline shape
  localparam int NUM_STAGES = 8;
  localparam int COS_ENTRIES_DEFAULT = 512;

  // Port widths
  localparam int S_DATA_W   = 112;
  localparam int S_USER_W   = 2;
  localparam int M_DATA_W   = 24;
  localparam int M_USER_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Field widths
  localparam int MM_W     = 14;
  localparam int HEAD_W   = 24;
  localparam int OFF_W    = 13;
  localparam int MANG_W   = 16;
  localparam int WALL_W   = 15;
  localparam int GUARD_W  = 13;
  localparam int POS_W    = 18;
  localparam int INCH_W   = 18;
  localparam int ANGLE_W  = 16;
  localparam int ERR_W    = 13;
  localparam int COS_W    = 17;
  localparam int SUM_W    = 25;
  localparam int QUOT_W   = 9;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    FUNC_GUARDED  = 2'd0,
    FUNC_ALWAYS   = 2'd1,
    FUNC_FALLBACK = 2'd2
  } func_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_HALF = 2'd0,
    CFG_MIN_MM    = 2'd1,
    CFG_MAX_MM    = 2'd2,
    CFG_GUARD     = 2'd3
  } cfg_index_t;

  // Register reset values
  localparam logic [WALL_W-1:0]  WALL_HALF_RST = 15'd17984;
  localparam logic [MM_W-1:0]    MIN_MM_RST    = 14'd30;
  localparam logic [MM_W-1:0]    MAX_MM_RST    = 14'd2000;
  localparam logic [GUARD_W-1:0] GUARD_RST     = 13'd800;

  // Millimetres to inches Q8: (mm * 1280 + 63) / 127 by reciprocal
  localparam logic [SUM_W-1:0] INCH_BIAS  = 25'd63;
  localparam logic [29:0]      INCH_RECIP = 30'd541098243;
  localparam int               INCH_SHIFT = 36;

  // Angle reduction modulo a full turn by reciprocal
  localparam logic [SUM_W-1:0]   ANG_BIAS  = 25'd8424000;
  localparam logic [26:0]        ANG_RECIP = 27'd122167959;
  localparam int                 ANG_SHIFT = 42;
  localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd36000;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'd18000;

  // Wall sectors and their normals
  localparam logic [ANGLE_W-1:0] SECTOR_NE = 16'd4500;
  localparam logic [ANGLE_W-1:0] SECTOR_SE = 16'd13500;
  localparam logic [ANGLE_W-1:0] SECTOR_SW = 16'd22500;
  localparam logic [ANGLE_W-1:0] SECTOR_NW = 16'd31500;
  localparam logic [ANGLE_W-1:0] TGT_EAST  = 16'd9000;
  localparam logic [ANGLE_W-1:0] TGT_SOUTH = 16'd18000;
  localparam logic [ANGLE_W-1:0] TGT_WEST  = 16'd27000;

  // Cosine index: (d * entries + 2250) / 4500 by reciprocal
  localparam int          K_SPAN  = 4500;
  localparam int          K_BIAS  = 2250;
  localparam logic [27:0] K_RECIP = 28'd244335918;
  localparam int          K_SHIFT = 40;

  // Cosine series, pi/4 in Q30 and the term divisors
  localparam logic [63:0] QUARTER_PI_Q30 = 64'd843314857;
  localparam logic [7:0]  TAYLOR_DIV [6] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

  // Output saturation
  localparam logic signed [20:0] POS_MAX = 21'sd131071;
  localparam logic signed [20:0] POS_MIN = -21'sd131072;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [WALL_W-1:0]  wall_half;
    logic [MM_W-1:0]    min_mm;
    logic [MM_W-1:0]    max_mm;
    logic [GUARD_W-1:0] guard_angle;
  } cfg_t;

  typedef struct packed {
    func_t                    func;
    logic [HEAD_W-1:0]        heading;
    logic [MM_W-1:0]          primary_mm;
    logic                     primary_present;
    logic [OFF_W-1:0]         primary_mount_offset;
    logic [MANG_W-1:0]        primary_mount_angle;
    logic [MM_W-1:0]          backup_mm;
    logic                     backup_present;
    logic [OFF_W-1:0]         backup_mount_offset;
    logic [MANG_W-1:0]        backup_mount_angle;
  } in_item_t;

  // Reduced angle and scaled reading
  typedef struct packed {
    logic               upd;
    logic               guard;
    logic [INCH_W-1:0]  inches;
    logic [OFF_W-1:0]   off;
    logic [ANGLE_W-1:0] angle;
  } front_t;

  // Wall choice and what rides along to the position stage
  typedef struct packed {
    logic              upd;
    logic              is_x;
    logic              wall_pos;
    logic [INCH_W-1:0] inches;
    logic [OFF_W-1:0]  off;
  } side_t;

  typedef struct packed {
    logic             update_valid;
    logic             axis_is_x;
    logic [POS_W-1:0] new_position;
  } out_item_t;

endpackage

// File: hw/rtl/wdpf_front.sv
module wdpf_front (
  input  logic                clk,
  input  wdpf_pkg::stage_en_t adv,
  input  wdpf_pkg::in_item_t  item,
  input  wdpf_pkg::cfg_t      cfg,
  output wdpf_pkg::front_t    front
);
  import wdpf_pkg::*;

  localparam int ANG_PROD_W  = SUM_W + 27;
  localparam int INCH_PROD_W = SUM_W + 30;

  logic                p_gate, b_gate, use_p, use_b, sel_guard;
  logic [MM_W-1:0]     sel_mm;
  logic [MANG_W-1:0]   sel_ang;
  logic [OFF_W-1:0]    sel_off;

  // stage 1 registers
  logic                upd1, guard1;
  logic [SUM_W-1:0]    sum1, xin1;
  logic [OFF_W-1:0]    off1;

  // stage 2 registers
  logic                upd2, guard2;
  logic [SUM_W-1:0]    sum2;
  logic [QUOT_W-1:0]   quot2;
  logic [INCH_W-1:0]   inches2;
  logic [OFF_W-1:0]    off2;

  logic [ANG_PROD_W-1:0]  ang_prod;
  logic [INCH_PROD_W-1:0] inch_prod;

  // Sensor choice and range gate
  always_comb begin
    p_gate    = (item.primary_mm > cfg.min_mm) && (item.primary_mm <= cfg.max_mm);
    b_gate    = (item.backup_mm > cfg.min_mm) && (item.backup_mm <= cfg.max_mm);
    use_p     = 1'b0;
    use_b     = 1'b0;
    sel_guard = 1'b0;
    unique case (item.func)
      FUNC_GUARDED: begin
        use_p     = item.primary_present && p_gate;
        sel_guard = 1'b1;
      end
      FUNC_ALWAYS: begin
        use_p = item.primary_present;
      end
      FUNC_FALLBACK: begin
        use_p = item.primary_present && p_gate;
        use_b = !(item.primary_present && p_gate) && item.backup_present && b_gate;
      end
      default: begin
        use_p = 1'b0;
      end
    endcase
    sel_mm  = use_b ? item.backup_mm : item.primary_mm;
    sel_ang = use_b ? item.backup_mount_angle : item.primary_mount_angle;
    sel_off = use_b ? item.backup_mount_offset : item.primary_mount_offset;
  end

  // Stage 1: biased heading sum (always positive) and scaled reading
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      upd1   <= use_p || use_b;
      guard1 <= sel_guard;
      sum1   <= {item.heading[HEAD_W-1], item.heading}
                + {{(SUM_W-MANG_W){sel_ang[MANG_W-1]}}, sel_ang}
                + ANG_BIAS;
      xin1   <= {1'b0, sel_mm, 10'b0} + {3'b0, sel_mm, 8'b0} + INCH_BIAS;
      off1   <= sel_off;
    end
  end

  // Stage 2: reciprocal multiplies
  assign ang_prod  = ANG_PROD_W'(sum1) * ANG_PROD_W'(ANG_RECIP);
  assign inch_prod = INCH_PROD_W'(xin1) * INCH_PROD_W'(INCH_RECIP);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      upd2    <= upd1;
      guard2  <= guard1;
      sum2    <= sum1;
      quot2   <= ang_prod[ANG_SHIFT +: QUOT_W];
      inches2 <= inch_prod[INCH_SHIFT +: INCH_W];
      off2    <= off1;
    end
  end

  // Stage 3: remainder of the full turn
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      front.upd    <= upd2;
      front.guard  <= guard2;
      front.inches <= inches2;
      front.off    <= off2;
      front.angle  <= ANGLE_W'(sum2 - SUM_W'(quot2) * SUM_W'(FULL_TURN));
    end
  end

endmodule

// File: hw/rtl/wdpf_wall.sv
module wdpf_wall #(
  parameter int COS_TABLE_ENTRIES = wdpf_pkg::COS_ENTRIES_DEFAULT
) (
  input  logic                                 clk,
  input  wdpf_pkg::stage_en_t                  adv,
  input  wdpf_pkg::front_t                     front,
  input  logic [wdpf_pkg::GUARD_W-1:0]         guard_angle,
  output logic [$clog2(COS_TABLE_ENTRIES+1)-1:0] k,
  output wdpf_pkg::side_t                      side
);
  import wdpf_pkg::*;

  localparam int KW    = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int KX_W  = $clog2(K_SPAN * COS_TABLE_ENTRIES + K_BIAS + 1);
  localparam int KP_W  = K_SHIFT + KW;
  localparam logic [KW-1:0] K_MAX = KW'(COS_TABLE_ENTRIES);

  logic               is_x, wall_pos, guard_fail;
  logic [ANGLE_W-1:0] a, diff;
  logic [ERR_W-1:0]   d;

  logic [KX_W-1:0]    x4;
  side_t              side4;
  logic [KP_W-1:0]    k_prod;
  logic [KW-1:0]      k_raw;

  assign a = front.angle;

  // Nearest wall and angle to its normal
  always_comb begin
    is_x     = 1'b0;
    wall_pos = 1'b1;
    priority if (a > SECTOR_NE && a <= SECTOR_SE) begin
      is_x = 1'b1;
      diff = (a > TGT_EAST) ? a - TGT_EAST : TGT_EAST - a;
    end else if (a > SECTOR_SE && a <= SECTOR_SW) begin
      wall_pos = 1'b0;
      diff     = (a > TGT_SOUTH) ? a - TGT_SOUTH : TGT_SOUTH - a;
    end else if (a > SECTOR_SW && a <= SECTOR_NW) begin
      is_x     = 1'b1;
      wall_pos = 1'b0;
      diff     = (a > TGT_WEST) ? a - TGT_WEST : TGT_WEST - a;
    end else begin
      // north wall wraps through zero
      diff = (a > HALF_TURN) ? FULL_TURN - a : a;
    end
    d          = ERR_W'(diff);
    guard_fail = front.guard && (d > guard_angle);
  end

  // Stage 4: wall choice, guard and scaled index numerator
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      side4.upd     <= front.upd && !guard_fail;
      side4.is_x    <= is_x;
      side4.wall_pos <= wall_pos;
      side4.inches  <= front.inches;
      side4.off     <= front.off;
      x4            <= KX_W'(d) * KX_W'(COS_TABLE_ENTRIES) + KX_W'(K_BIAS);
    end
  end

  assign k_prod = KP_W'(x4) * KP_W'(K_RECIP);
  assign k_raw  = k_prod[K_SHIFT +: KW];

  // Stage 5: table index
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      k             <= (k_raw > K_MAX) ? K_MAX : k_raw;
      side.upd      <= side4.upd;
      side.is_x     <= side4.is_x;
      side.wall_pos <= side4.wall_pos;
      side.inches   <= side4.inches;
      side.off      <= side4.off;
    end
  end

endmodule

// File: hw/rtl/wdpf_cos_rom.sv
module wdpf_cos_rom #(
  parameter int COS_TABLE_ENTRIES = wdpf_pkg::COS_ENTRIES_DEFAULT
) (
  input  logic                                   clk,
  input  wdpf_pkg::stage_en_t                    adv,
  input  logic [$clog2(COS_TABLE_ENTRIES+1)-1:0] k,
  input  wdpf_pkg::side_t                        side_in,
  output logic [wdpf_pkg::COS_W-1:0]             cos_val,
  output wdpf_pkg::side_t                        side_out
);
  import wdpf_pkg::*;

  // cos(k * pi/4 / entries) in Q16, series to the x^12 term in Q30
  function automatic logic [COS_W-1:0] cos_entry(input int unsigned idx);
    logic [63:0]        th;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [64:0] sum;
    th   = (64'(idx) * QUARTER_PI_Q30 + 64'(COS_TABLE_ENTRIES / 2))
           / 64'(COS_TABLE_ENTRIES);
    x2   = (th * th + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    sum  = 65'sd1 <<< 30;
    for (int i = 1; i <= 6; i++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[i-1]);
      if ((i % 2) == 1) begin
        sum = sum - $signed({1'b0, term});
      end else begin
        sum = sum + $signed({1'b0, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return COS_W'((sum + 65'sd8192) >>> 14);
  endfunction

  logic [COS_W-1:0] rom [COS_TABLE_ENTRIES+1];

  for (genvar g = 0; g <= COS_TABLE_ENTRIES; g++) begin : g_rom
    assign rom[g] = cos_entry(g);
  end

  // Stage 6: registered table read
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      cos_val  <= rom[k];
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/wdpf_back.sv
module wdpf_back (
  input  logic                        clk,
  input  wdpf_pkg::stage_en_t         adv,
  input  logic [wdpf_pkg::COS_W-1:0]  cos_val,
  input  wdpf_pkg::side_t             side,
  input  logic [wdpf_pkg::WALL_W-1:0] wall_half,
  output wdpf_pkg::out_item_t         result
);
  import wdpf_pkg::*;

  localparam int PROD_W = INCH_W + COS_W;

  logic [PROD_W-1:0]  prod7;
  side_t              side7;
  logic [INCH_W-1:0]  corr;
  logic signed [20:0] beam_dist, wall_s, pos, pos_sat;

  // Stage 7: cosine correction multiply
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      prod7 <= PROD_W'(side.inches) * PROD_W'(cos_val);
      side7 <= side;
    end
  end

  // Round, add offset, distance from the wall, saturate
  always_comb begin
    corr      = INCH_W'((prod7 + PROD_W'(32768)) >> 16);
    beam_dist = $signed({3'b0, corr}) + $signed({{8{side7.off[OFF_W-1]}}, side7.off});
    wall_s    = $signed({6'b0, wall_half});
    if (side7.wall_pos && (wall_half != '0)) begin
      pos = wall_s - beam_dist;
    end else begin
      pos = beam_dist - wall_s;
    end
    if (pos > POS_MAX) begin
      pos_sat = POS_MAX;
    end else if (pos < POS_MIN) begin
      pos_sat = POS_MIN;
    end else begin
      pos_sat = pos;
    end
  end

  // Stage 8: output register, fields cleared when there is no update
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      result.update_valid <= side7.upd;
      result.axis_is_x    <= side7.upd && side7.is_x;
      result.new_position <= side7.upd ? POS_W'(pos_sat) : '0;
    end
  end

endmodule

// File: hw/rtl/wall_distance_position_fix.sv
// Wall distance position fix.
// Input channel s_*: one transaction carries a heading, one or two range
// readings with their mount angle and offset, and the mode in s_tuser.
// Output channel m_*: exactly one transaction per input transaction, in
// order; m_tuser flags whether a correction was made and on which axis,
// m_tdata holds the corrected coordinate (inches Q8, saturated).
// Configuration: cfg_we/cfg_index/cfg_data write the wall half distance,
// reading gate limits and angle guard; write only while the pipe is empty.
// Eight register stages: m_tvalid rises once a transaction has passed
// two rounds of reciprocal multiplies, the registered cosine table read
// and the correction multiply. Throughput is one per clock if not stalled.
// When m_tready is low, stages fill up toward the input and s_tready drops
// only once every stage holds a transaction; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipe and restores the register
// defaults; the cosine table is constant and needs no fill.
module wall_distance_position_fix #(
  parameter int COS_TABLE_ENTRIES = wdpf_pkg::COS_ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // heading, primary_mm, primary_present, primary_mount_offset,
  // primary_mount_angle, backup_mm, backup_present, backup_mount_offset,
  // backup_mount_angle
  input  logic [wdpf_pkg::S_DATA_W-1:0]   s_tdata,
  // func
  input  logic [wdpf_pkg::S_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_position, zero fill
  output logic [wdpf_pkg::M_DATA_W-1:0]   m_tdata,
  // update_valid, axis_is_x
  output logic [wdpf_pkg::M_USER_W-1:0]   m_tuser,
  input  logic                            cfg_we,
  input  logic [wdpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wdpf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wdpf_pkg::*;

  localparam int KW = $clog2(COS_TABLE_ENTRIES + 1);

  cfg_t                 cfg;
  in_item_t             item;
  front_t               front;
  side_t                side5, side6;
  logic [KW-1:0]        k;
  logic [COS_W-1:0]     cos_val;
  out_item_t            result;
  stage_en_t            adv;
  logic [NUM_STAGES-1:0] vld;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_half   <= WALL_HALF_RST;
      cfg.min_mm      <= MIN_MM_RST;
      cfg.max_mm      <= MAX_MM_RST;
      cfg.guard_angle <= GUARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WALL_HALF: cfg.wall_half   <= cfg_data[WALL_W-1:0];
        CFG_MIN_MM:    cfg.min_mm      <= cfg_data[MM_W-1:0];
        CFG_MAX_MM:    cfg.max_mm      <= cfg_data[MM_W-1:0];
        CFG_GUARD:     cfg.guard_angle <= cfg_data[GUARD_W-1:0];
        default: begin
          cfg.wall_half <= cfg.wall_half;
        end
      endcase
    end
  end

  // Unpack the input transaction
  always_comb begin
    item.func                 = func_t'(s_tuser[1:0]);
    item.heading              = s_tdata[23:0];
    item.primary_mm           = s_tdata[37:24];
    item.primary_present      = s_tdata[38];
    item.primary_mount_offset = s_tdata[51:39];
    item.primary_mount_angle  = s_tdata[67:52];
    item.backup_mm            = s_tdata[81:68];
    item.backup_present       = s_tdata[82];
    item.backup_mount_offset  = s_tdata[95:83];
    item.backup_mount_angle   = s_tdata[111:96];
  end

  // Stage advance: a stage loads when it is empty or its successor moves
  assign adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
  for (genvar i = 0; i < NUM_STAGES - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = adv[0];

  wdpf_front u_front (
    .clk   (clk),
    .adv   (adv),
    .item  (item),
    .cfg   (cfg),
    .front (front)
  );

  wdpf_wall #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_wall (
    .clk         (clk),
    .adv         (adv),
    .front       (front),
    .guard_angle (cfg.guard_angle),
    .k           (k),
    .side        (side5)
  );

  wdpf_cos_rom #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_cos_rom (
    .clk      (clk),
    .adv      (adv),
    .k        (k),
    .side_in  (side5),
    .cos_val  (cos_val),
    .side_out (side6)
  );

  wdpf_back u_back (
    .clk       (clk),
    .adv       (adv),
    .cos_val   (cos_val),
    .side      (side6),
    .wall_half (cfg.wall_half),
    .result    (result)
  );

  // Output transaction
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = {{(M_DATA_W-POS_W){1'b0}}, result.new_position};
  assign m_tuser  = {result.axis_is_x, result.update_valid};

  // A result without a correction carries zero fields
  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("no-update result carries nonzero fields");

  // Input is only held off when the output holds a waiting transaction
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // Reset empties the pipe
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
